// ----- hdl/knob_soft_takeover_macros.svh -----
// Assertion macros for the knob soft takeover block.
// Included by the top level; no other dependencies.
`ifndef KNOB_SOFT_TAKEOVER_MACROS_SVH
`define KNOB_SOFT_TAKEOVER_MACROS_SVH

`ifndef ASSERT_OFF
`define KST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("knob_soft_takeover: check failed");
`define KST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("knob_soft_takeover: check failed");
`else
`define KST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KST_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/kst_pkg.sv -----
// Shared constants, widths and operation codes for the knob soft takeover block.
// No dependencies.
`default_nettype none

package kst_pkg;

    localparam int NUM_CONTROLS = 16;
    localparam int VALUE_BITS   = 16;
    localparam int OP_W         = 2;
    localparam int INDEX_W      = 5;
    localparam int OUT_INDEX_W  = 4;
    localparam int MASK_W       = 16;
    localparam int CTRL_W       = (NUM_CONTROLS > 1) ? $clog2(NUM_CONTROLS) : 1;

    localparam int ONE_INT = (1 << VALUE_BITS) - 1;
    localparam int EPS_INT = (ONE_INT + 50) / 100;

    localparam logic [VALUE_BITS-1:0] VAL_ONE = VALUE_BITS'(ONE_INT);
    localparam logic [VALUE_BITS-1:0] VAL_EPS = VALUE_BITS'(EPS_INT);
    localparam logic [VALUE_BITS-1:0] VAL_HIGH = VALUE_BITS'(ONE_INT - EPS_INT);

    localparam logic [MASK_W-1:0] KNOB_MASK_RESET = '1;

    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_LOCK   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    typedef logic [VALUE_BITS-1:0] value_t;

endpackage

`default_nettype wire

// ----- hdl/kst_if.sv -----
// Handshake channels of the knob soft takeover block: request, result, config.
// Depends on kst_pkg.
`default_nettype none

interface kst_req_if;
    logic                        valid;
    logic                        ready;
    logic [kst_pkg::OP_W-1:0]    operation;
    logic [kst_pkg::INDEX_W-1:0] control_index;
    kst_pkg::value_t             sample_value;
    kst_pkg::value_t             preset_value;

    modport source (output valid, operation, control_index, sample_value, preset_value,
                    input ready);
    modport sink   (input valid, operation, control_index, sample_value, preset_value,
                    output ready);
endinterface

interface kst_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [kst_pkg::OUT_INDEX_W-1:0] out_index;
    kst_pkg::value_t                 mapped_value;
    logic                            still_locked;

    modport source (output valid, out_index, mapped_value, still_locked, input ready);
    modport sink   (input valid, out_index, mapped_value, still_locked, output ready);
endinterface

interface kst_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [kst_pkg::MASK_W-1:0] knob_mask;

    modport source (output valid, knob_mask, input ready);
    modport sink   (input valid, knob_mask, output ready);
endinterface

`default_nettype wire

// ----- hdl/knob_soft_takeover.sv -----
// Soft takeover for a bank of knob controls: per-control lock state and an
// iterative multiply/divide unit. Depends on kst_pkg, kst_if and the macros header.
//
// Usage:
//   req: one transaction per operation (sample, lock, read) for one control.
//   rsp: zero or one result transaction per request.
//   cfg: writes the knob mask; always ready, write only while the block is idle.
// Timing:
//   req.ready is high only while the sequencer is idle. A lock, an ignored or
//   out-of-range request and any request without a result return from S_EVAL
//   to idle. A read, a pass-through or a result that needs no scaling goes from
//   S_EVAL to S_EMIT, which loads the output register. A scaled result uses
//   the shared 16x16 multiplier (S_MUL) and a restoring divider that yields one
//   quotient bit a cycle (S_DIV); S_FIN then adds the base and clamps before S_EMIT.
// Stall:
//   The output register holds a result until rsp.ready; the next request is
//   accepted meanwhile and waits at its own result until the register frees.
// Reset:
//   All per-control state clears, the knob mask becomes all ones, the output
//   register empties and req.ready is high from reset on.
`default_nettype none

`include "knob_soft_takeover_macros.svh"

module knob_soft_takeover (
    input  wire logic  clk,
    input  wire logic  rst_n,
    kst_req_if.sink    req,
    kst_rsp_if.source  rsp,
    kst_cfg_if.sink    cfg
);
    import kst_pkg::*;

    localparam int VB    = VALUE_BITS;
    localparam int NUM_W = 2 * VB;
    localparam int CNT_W = $clog2(VB + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [MASK_W-1:0]  mask_reg;

    logic [OP_W-1:0]    op_reg, op_next;
    logic [INDEX_W-1:0] ci_reg, ci_next;
    value_t             hw_reg, hw_next;
    value_t             pre_reg, pre_next;

    logic               lock_flag_reg  [NUM_CONTROLS];
    value_t             preset_reg     [NUM_CONTROLS];
    value_t             lpos_reg       [NUM_CONTROLS];
    logic               lknown_reg     [NUM_CONTROLS];
    value_t             prev_reg       [NUM_CONTROLS];
    logic               prev_known_reg [NUM_CONTROLS];
    value_t             raw_reg        [NUM_CONTROLS];

    value_t             mul_a_reg, mul_a_next;
    value_t             mul_b_reg, mul_b_next;
    value_t             half_reg, half_next;
    value_t             div_reg, div_next;
    value_t             base_reg, base_next;
    value_t             rem_reg, rem_next;
    logic [VB:0]        shreg_reg, shreg_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    value_t             res_reg, res_next;
    logic               res_lock_reg, res_lock_next;

    logic               out_valid_reg, out_valid_next;
    logic [OUT_INDEX_W-1:0] out_index_reg, out_index_next;
    value_t             out_value_reg, out_value_next;
    logic               out_lock_reg, out_lock_next;

    logic               lock_wr, lock_val, preset_wr, lpos_wr, lknown_wr, lknown_val;
    logic               prev_wr, raw_wr;

    logic [CTRL_W-1:0]  ci;
    logic               ci_ok, is_knob, cur_lock, cur_lknown, crossed;
    value_t             x, kk, prev, cur_raw, d_cur, d_prev;
    logic [VB:0]        kk_eps, sat_sum, trial;
    logic [NUM_W-1:0]   prod;
    logic [VB+1:0]      fin_sum;

    function automatic value_t absdiff(input value_t a, input value_t b);
        absdiff = (a >= b) ? (a - b) : (b - a);
    endfunction

    assign ci         = ci_reg[CTRL_W-1:0];
    assign ci_ok      = (32'(ci_reg) < 32'(NUM_CONTROLS));
    assign is_knob    = (ci_reg < INDEX_W'(MASK_W)) && mask_reg[ci_reg[OUT_INDEX_W-1:0]];
    assign cur_lock   = lock_flag_reg[ci];
    assign cur_lknown = lknown_reg[ci];
    assign cur_raw    = raw_reg[ci];
    assign x          = preset_reg[ci];
    assign kk         = cur_lknown ? lpos_reg[ci] : hw_reg;
    assign prev       = prev_known_reg[ci] ? prev_reg[ci] : hw_reg;
    assign d_cur      = absdiff(hw_reg, x);
    assign d_prev     = absdiff(prev, x);
    assign crossed    = (d_cur <= VAL_EPS) || (d_prev <= VAL_EPS)
                        || ((prev < x) && (hw_reg > x)) || ((prev > x) && (hw_reg < x));
    assign kk_eps     = {1'b0, kk} + {1'b0, VAL_EPS};
    assign sat_sum    = {1'b0, x} + {1'b0, hw_reg - kk};
    assign prod       = NUM_W'(mul_a_reg) * NUM_W'(mul_b_reg) + NUM_W'(half_reg);
    assign trial      = {rem_reg, shreg_reg[VB]};
    assign fin_sum    = (VB+2)'(base_reg) + (VB+2)'(shreg_reg);

    assign req.ready  = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;

    assign rsp.valid        = out_valid_reg;
    assign rsp.out_index    = out_index_reg;
    assign rsp.mapped_value = out_value_reg;
    assign rsp.still_locked = out_lock_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        ci_next        = ci_reg;
        hw_next        = hw_reg;
        pre_next       = pre_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        half_next      = half_reg;
        div_next       = div_reg;
        base_next      = base_reg;
        rem_next       = rem_reg;
        shreg_next     = shreg_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        res_lock_next  = res_lock_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_index_next = out_index_reg;
        out_value_next = out_value_reg;
        out_lock_next  = out_lock_reg;
        lock_wr        = 1'b0;
        lock_val       = 1'b0;
        preset_wr      = 1'b0;
        lpos_wr        = 1'b0;
        lknown_wr      = 1'b0;
        lknown_val     = 1'b0;
        prev_wr        = 1'b0;
        raw_wr         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.operation;
                    ci_next    = req.control_index;
                    hw_next    = req.sample_value;
                    pre_next   = req.preset_value;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_IDLE;
                if (ci_ok)
                begin
                    case (op_reg)
                        OP_LOCK:
                        begin
                            lock_wr    = 1'b1;
                            lock_val   = 1'b1;
                            preset_wr  = 1'b1;
                            lknown_wr  = 1'b1;
                            lknown_val = 1'b0;
                        end
                        OP_READ:
                        begin
                            res_next      = cur_raw;
                            res_lock_next = cur_lock;
                            state_next    = S_EMIT;
                        end
                        OP_SAMPLE:
                        begin
                            prev_wr = 1'b1;
                            if (!cur_lock)
                            begin
                                raw_wr        = 1'b1;
                                res_next      = hw_reg;
                                res_lock_next = 1'b0;
                                state_next    = S_EMIT;
                            end
                            else if (is_knob)
                            begin
                                if (!cur_lknown)
                                begin
                                    lpos_wr    = 1'b1;
                                    lknown_wr  = 1'b1;
                                    lknown_val = 1'b1;
                                end
                                if ((hw_reg <= VAL_EPS) || (hw_reg >= VAL_HIGH))
                                begin
                                    lock_wr  = 1'b1;
                                    lock_val = 1'b0;
                                end
                                else
                                begin
                                    raw_wr = 1'b1;
                                    if (crossed)
                                    begin
                                        lock_wr       = 1'b1;
                                        lock_val      = 1'b0;
                                        res_next      = x;
                                        res_lock_next = 1'b0;
                                        state_next    = S_EMIT;
                                    end
                                    else
                                    begin
                                        res_lock_next = 1'b1;
                                        if ({1'b0, hw_reg} <= kk_eps)
                                        begin
                                            if (kk <= VAL_EPS)
                                            begin
                                                res_next   = hw_reg;
                                                state_next = S_EMIT;
                                            end
                                            else
                                            begin
                                                mul_a_next = hw_reg;
                                                mul_b_next = x;
                                                half_next  = kk >> 1;
                                                div_next   = kk;
                                                base_next  = '0;
                                                state_next = S_MUL;
                                            end
                                        end
                                        else if (kk >= VAL_HIGH)
                                        begin
                                            res_next   = sat_sum[VB] ? VAL_ONE : sat_sum[VB-1:0];
                                            state_next = S_EMIT;
                                        end
                                        else
                                        begin
                                            mul_a_next = hw_reg - kk;
                                            mul_b_next = VAL_ONE - x;
                                            half_next  = (VAL_ONE - kk) >> 1;
                                            div_next   = VAL_ONE - kk;
                                            base_next  = x;
                                            state_next = S_MUL;
                                        end
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                rem_next   = VB'(prod[NUM_W-1:VB+1]);
                shreg_next = prod[VB:0];
                cnt_next   = CNT_W'(VB);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (trial >= {1'b0, div_reg})
                begin
                    rem_next   = VB'(trial - {1'b0, div_reg});
                    shreg_next = {shreg_reg[VB-1:0], 1'b1};
                end
                else
                begin
                    rem_next   = trial[VB-1:0];
                    shreg_next = {shreg_reg[VB-1:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                res_next   = (fin_sum > (VB+2)'(VAL_ONE)) ? VAL_ONE : fin_sum[VB-1:0];
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = ci_reg[OUT_INDEX_W-1:0];
                    out_value_next = res_reg;
                    out_lock_next  = res_lock_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            mask_reg      <= KNOB_MASK_RESET;
            for (int i = 0; i < NUM_CONTROLS; i++)
            begin
                lock_flag_reg[i]  <= 1'b0;
                preset_reg[i]     <= '0;
                lpos_reg[i]       <= '0;
                lknown_reg[i]     <= 1'b0;
                prev_reg[i]       <= '0;
                prev_known_reg[i] <= 1'b0;
                raw_reg[i]        <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                mask_reg <= cfg.knob_mask;
            end
            if (lock_wr)
            begin
                lock_flag_reg[ci] <= lock_val;
            end
            if (preset_wr)
            begin
                preset_reg[ci] <= pre_reg;
            end
            if (lpos_wr)
            begin
                lpos_reg[ci] <= hw_reg;
            end
            if (lknown_wr)
            begin
                lknown_reg[ci] <= lknown_val;
            end
            if (prev_wr)
            begin
                prev_reg[ci]       <= hw_reg;
                prev_known_reg[ci] <= 1'b1;
            end
            if (raw_wr)
            begin
                raw_reg[ci] <= hw_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        ci_reg        <= ci_next;
        hw_reg        <= hw_next;
        pre_reg       <= pre_next;
        mul_a_reg     <= mul_a_next;
        mul_b_reg     <= mul_b_next;
        half_reg      <= half_next;
        div_reg       <= div_next;
        base_reg      <= base_next;
        rem_reg       <= rem_next;
        shreg_reg     <= shreg_next;
        cnt_reg       <= cnt_next;
        res_reg       <= res_next;
        res_lock_reg  <= res_lock_next;
        out_index_reg <= out_index_next;
        out_value_reg <= out_value_next;
        out_lock_reg  <= out_lock_next;
    end

    `KST_ASSERT_NXT(a_accept_evaluates, clk, rst_n, req.valid && req.ready, state_reg == S_EVAL)
    `KST_ASSERT_IMP(a_divisor_large, clk, rst_n, state_reg == S_MUL, div_reg > VAL_EPS)
    `KST_ASSERT_NXT(a_div_ends, clk, rst_n, state_reg == S_DIV && cnt_reg == '0, state_reg == S_FIN)
    `KST_ASSERT_IMP(a_load_from_emit, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == S_EMIT)

endmodule

`default_nettype wire
